// File: rtl/core/ilpd_pkg.sv
// Shared types, codes and opcode tables for the instruction length predecoder.
package ilpd_pkg;

  typedef enum logic [3:0] {
    MD_INV = 4'd0, MD_IMP = 4'd1, MD_IMB = 4'd2, MD_IMW = 4'd3, MD_DIR = 4'd4,
    MD_EXT = 4'd5, MD_IND = 4'd6, MD_REB = 4'd7, MD_REW = 4'd8, MD_RPAIR = 4'd9,
    MD_SSTK = 4'd10, MD_USTK = 4'd11
  } mode_t;

  localparam logic [7:0] MN_ILL = 8'd0, MN_ABX = 8'd1, MN_ADCA = 8'd2, MN_ADCB = 8'd3,
    MN_ADDA = 8'd4, MN_ADDB = 8'd5, MN_ADDD = 8'd6, MN_ANDA = 8'd7, MN_ANDB = 8'd8,
    MN_ANDCC = 8'd9, MN_ASLA = 8'd10, MN_ASLB = 8'd11, MN_ASL = 8'd12, MN_ASRA = 8'd13,
    MN_ASRB = 8'd14, MN_ASR = 8'd15, MN_BCC = 8'd16, MN_BCS = 8'd18, MN_BEQ = 8'd20,
    MN_BGE = 8'd22, MN_BGT = 8'd24, MN_BHI = 8'd26, MN_BITA = 8'd28, MN_BITB = 8'd29,
    MN_BLE = 8'd30, MN_BLS = 8'd32, MN_BLT = 8'd34, MN_BMI = 8'd36, MN_BNE = 8'd38,
    MN_BPL = 8'd40, MN_BRA = 8'd42, MN_LBRA = 8'd43, MN_BRN = 8'd44, MN_BSR = 8'd46,
    MN_LBSR = 8'd47, MN_BVC = 8'd48, MN_BVS = 8'd50, MN_CLRA = 8'd52, MN_CLRB = 8'd53,
    MN_CLR = 8'd54, MN_CMPA = 8'd55, MN_CMPB = 8'd56, MN_CMPD = 8'd57, MN_CMPS = 8'd58,
    MN_CMPU = 8'd59, MN_CMPX = 8'd60, MN_CMPY = 8'd61, MN_COMA = 8'd62, MN_COMB = 8'd63,
    MN_COM = 8'd64, MN_CWAI = 8'd65, MN_DAA = 8'd66, MN_DECA = 8'd67, MN_DECB = 8'd68,
    MN_DEC = 8'd69, MN_EORA = 8'd70, MN_EORB = 8'd71, MN_EXG = 8'd72, MN_INCA = 8'd73,
    MN_INCB = 8'd74, MN_INC = 8'd75, MN_JMP = 8'd76, MN_JSR = 8'd77, MN_LDA = 8'd78,
    MN_LDB = 8'd79, MN_LDD = 8'd80, MN_LDS = 8'd81, MN_LDU = 8'd82, MN_LDX = 8'd83,
    MN_LDY = 8'd84, MN_LEAS = 8'd85, MN_LEAU = 8'd86, MN_LEAX = 8'd87, MN_LEAY = 8'd88,
    MN_LSRA = 8'd89, MN_LSRB = 8'd90, MN_LSR = 8'd91, MN_MUL = 8'd92, MN_NEGA = 8'd93,
    MN_NEGB = 8'd94, MN_NEG = 8'd95, MN_NOP = 8'd96, MN_ORA = 8'd97, MN_ORB = 8'd98,
    MN_ORCC = 8'd99, MN_PSHS = 8'd100, MN_PSHU = 8'd101, MN_PULS = 8'd102,
    MN_PULU = 8'd103, MN_ROLA = 8'd104, MN_ROLB = 8'd105, MN_ROL = 8'd106,
    MN_RORA = 8'd107, MN_RORB = 8'd108, MN_ROR = 8'd109, MN_RTI = 8'd110,
    MN_RTS = 8'd111, MN_SBCA = 8'd112, MN_SBCB = 8'd113, MN_SEX = 8'd114,
    MN_STA = 8'd115, MN_STB = 8'd116, MN_STD = 8'd117, MN_STS = 8'd118,
    MN_STU = 8'd119, MN_STX = 8'd120, MN_STY = 8'd121, MN_SUBA = 8'd122,
    MN_SUBB = 8'd123, MN_SUBD = 8'd124, MN_SWI = 8'd125, MN_SWI2 = 8'd126,
    MN_SWI3 = 8'd127, MN_SYNC = 8'd128, MN_TFR = 8'd129, MN_TSTA = 8'd130,
    MN_TSTB = 8'd131, MN_TST = 8'd132, MN_RESET = 8'd133;

  localparam logic [7:0] PREFIX_P1 = 8'h10;
  localparam logic [7:0] PREFIX_P2 = 8'h11;
  localparam logic [7:0] EXT_IND_POST = 8'h9F;

  typedef enum logic [3:0] {
    IF_5BIT = 4'd0, IF_INC1 = 4'd1, IF_INC2 = 4'd2, IF_DEC1 = 4'd3, IF_DEC2 = 4'd4,
    IF_ZERO = 4'd5, IF_ACCB = 4'd6, IF_ACCA = 4'd7, IF_OFF8 = 4'd8, IF_OFF16 = 4'd9,
    IF_ACCD = 4'd10, IF_PC8 = 4'd11, IF_PC16 = 4'd12, IF_EXTIND = 4'd13, IF_ILL = 4'd14
  } iform_t;

  typedef struct packed {
    logic [7:0] mn;
    mode_t      md;
  } op_entry_t;

  localparam logic [7:0] MEM_OPS [16] = '{MN_NEG, MN_ILL, MN_ILL, MN_COM, MN_LSR,
    MN_ILL, MN_ROR, MN_ASR, MN_ASL, MN_ROL, MN_DEC, MN_ILL, MN_INC, MN_TST, MN_JMP,
    MN_CLR};
  localparam logic [7:0] ACCA_OPS [16] = '{MN_NEGA, MN_ILL, MN_ILL, MN_COMA, MN_LSRA,
    MN_ILL, MN_RORA, MN_ASRA, MN_ASLA, MN_ROLA, MN_DECA, MN_ILL, MN_INCA, MN_TSTA,
    MN_ILL, MN_CLRA};
  localparam logic [7:0] ACCB_OPS [16] = '{MN_NEGB, MN_ILL, MN_ILL, MN_COMB, MN_LSRB,
    MN_ILL, MN_RORB, MN_ASRB, MN_ASLB, MN_ROLB, MN_DECB, MN_ILL, MN_INCB, MN_TSTB,
    MN_ILL, MN_CLRB};
  localparam logic [7:0] SHORT_BR [16] = '{MN_BRA, MN_BRN, MN_BHI, MN_BLS, MN_BCC,
    MN_BCS, MN_BNE, MN_BEQ, MN_BVC, MN_BVS, MN_BPL, MN_BMI, MN_BGE, MN_BLT, MN_BGT,
    MN_BLE};
  localparam logic [7:0] SIDE_A [16] = '{MN_SUBA, MN_CMPA, MN_SBCA, MN_SUBD, MN_ANDA,
    MN_BITA, MN_LDA, MN_STA, MN_EORA, MN_ADCA, MN_ORA, MN_ADDA, MN_CMPX, MN_JSR,
    MN_LDX, MN_STX};
  localparam logic [7:0] SIDE_B [16] = '{MN_SUBB, MN_CMPB, MN_SBCB, MN_ADDD, MN_ANDB,
    MN_BITB, MN_LDB, MN_STB, MN_EORB, MN_ADCB, MN_ORB, MN_ADDB, MN_LDD, MN_STD,
    MN_LDU, MN_STU};
  localparam op_entry_t ROW1 [16] = '{'{MN_ILL, MD_INV}, '{MN_ILL, MD_INV},
    '{MN_NOP, MD_IMP}, '{MN_SYNC, MD_IMP}, '{MN_ILL, MD_INV}, '{MN_ILL, MD_INV},
    '{MN_LBRA, MD_REW}, '{MN_LBSR, MD_REW}, '{MN_ILL, MD_INV}, '{MN_DAA, MD_IMP},
    '{MN_ORCC, MD_IMB}, '{MN_ILL, MD_INV}, '{MN_ANDCC, MD_IMB}, '{MN_SEX, MD_IMP},
    '{MN_EXG, MD_RPAIR}, '{MN_TFR, MD_RPAIR}};
  localparam op_entry_t ROW3 [16] = '{'{MN_LEAX, MD_IND}, '{MN_LEAY, MD_IND},
    '{MN_LEAS, MD_IND}, '{MN_LEAU, MD_IND}, '{MN_PSHS, MD_SSTK}, '{MN_PULS, MD_SSTK},
    '{MN_PSHU, MD_USTK}, '{MN_PULU, MD_USTK}, '{MN_ILL, MD_INV}, '{MN_RTS, MD_IMP},
    '{MN_ABX, MD_IMP}, '{MN_RTI, MD_IMP}, '{MN_CWAI, MD_IMB}, '{MN_MUL, MD_IMP},
    '{MN_RESET, MD_IMP}, '{MN_SWI, MD_IMP}};
  localparam mode_t COL_MODE [4] = '{MD_IMW, MD_DIR, MD_IND, MD_EXT};

endpackage

// File: rtl/core/instruction_length_predecoder_top.sv
// Instruction length predecoder top level: input register, decode, result register.
// When in_stall is low, one instruction window (address plus five bytes) is taken into
// the input register each cycle; its decode is then registered in the result register.
// One item per clock is sustained while out_stall is low: the window is decoded in one
// pass of table lookup and mux logic between the two registers. The result register
// advances when empty or taken, the input register when empty or the result advances.
module instruction_length_predecoder_top import ilpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [15:0] instr_address,
  input  logic        [7:0]  byte_zero,
  input  logic        [7:0]  byte_one,
  input  logic        [7:0]  byte_two,
  input  logic        [7:0]  byte_three,
  input  logic        [7:0]  byte_four,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [2:0]  length,
  output logic        [1:0]  page,
  output logic        [7:0]  mnemonic,
  output logic        [3:0]  mode,
  output logic        [15:0] operand,
  output logic        [7:0]  postbyte,
  output logic        [1:0]  index_register,
  output logic        [3:0]  index_form,
  output logic               index_indirect,
  output logic signed [16:0] index_offset,
  output logic               index_valid
);

  logic        s1_valid;
  logic [15:0] s1_addr;
  logic [7:0]  s1_b [5];
  logic        adv_out, adv_in;

  assign adv_out = !out_valid || !out_stall;
  assign adv_in = !s1_valid || adv_out;
  assign in_stall = !adv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv_in) begin
      s1_valid <= in_valid;
    end
    if (adv_in && in_valid) begin
      s1_addr <= instr_address;
      s1_b[0] <= byte_zero;
      s1_b[1] <= byte_one;
      s1_b[2] <= byte_two;
      s1_b[3] <= byte_three;
      s1_b[4] <= byte_four;
    end
  end

  // decode
  logic [1:0]  pg;
  logic        pfx;
  logic [7:0]  op, p0, p1, p2;
  op_entry_t   ent;

  assign pg = (s1_b[0] == PREFIX_P1) ? 2'd1 : (s1_b[0] == PREFIX_P2) ? 2'd2 : 2'd0;
  assign pfx = (pg != 2'd0);
  assign op = pfx ? s1_b[1] : s1_b[0];
  assign p0 = pfx ? s1_b[2] : s1_b[1];
  assign p1 = pfx ? s1_b[3] : s1_b[2];
  assign p2 = pfx ? s1_b[4] : s1_b[3];

  ilpd_lookup u_lookup (.page(pg), .op(op), .entry(ent));

  iform_t             ix_form;
  logic               ix_ind, ix_valid;
  logic signed [16:0] ix_off;
  logic [1:0]         ix_extra;

  ilpd_index u_index (
    .post(p0), .b1(p1), .b2(p2), .form(ix_form), .indirect(ix_ind),
    .offset(ix_off), .extra(ix_extra), .valid(ix_valid)
  );

  logic [2:0]  n, len_next;
  logic [15:0] opr_next, after, rel;
  logic [7:0]  post_next;
  logic        is_ind;

  assign n = pfx ? 3'd2 : 3'd1;
  assign is_ind = (ent.md == MD_IND);
  assign after = s1_addr + {13'd0, len_next};
  assign rel = (ent.md == MD_REB) ? {{8{p0[7]}}, p0} : {p0, p1};

  always_comb begin
    len_next = n;
    opr_next = '0;
    post_next = '0;
    unique case (ent.md)
      MD_IMB, MD_DIR: begin opr_next = {8'd0, p0}; len_next = n + 3'd1; end
      MD_IMW, MD_EXT: begin opr_next = {p0, p1}; len_next = n + 3'd2; end
      MD_REB: len_next = n + 3'd1;
      MD_REW: len_next = n + 3'd2;
      MD_RPAIR, MD_SSTK, MD_USTK: begin post_next = p0; len_next = n + 3'd1; end
      MD_IND: begin post_next = p0; len_next = n + 3'd1 + {1'b0, ix_extra}; end
      default: ;
    endcase
    if (ent.md == MD_REB || ent.md == MD_REW) opr_next = after + rel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= s1_valid;
    end
    if (adv_out && s1_valid) begin
      length <= len_next;
      page <= pg;
      mnemonic <= ent.mn;
      mode <= ent.md;
      operand <= opr_next;
      postbyte <= post_next;
      index_register <= is_ind ? p0[6:5] : 2'd0;
      index_form <= is_ind ? ix_form : IF_5BIT;
      index_indirect <= is_ind && ix_ind;
      index_offset <= is_ind ? ix_off : '0;
      index_valid <= is_ind && ix_valid;
    end
  end

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (length >= 3'd1 && length <= 3'd5))
    else $error("length out of range");
  a_inv_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mode == MD_INV) |-> (length == 3'd1 + {2'd0, page != 2'd0}))
    else $error("invalid opcode length wrong");
  a_noidx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mode != MD_IND) |-> (index_valid == 1'b0 && index_offset == '0))
    else $error("index fields set outside indexed mode");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(length) && $stable(operand)))
    else $error("result changed while stalled");

endmodule

// File: rtl/core/ilpd_lookup.sv
// Opcode table lookup: page and opcode to mnemonic and addressing mode.
module ilpd_lookup import ilpd_pkg::*; (
  input  logic [1:0] page,
  input  logic [7:0] op,
  output op_entry_t  entry
);

  logic [3:0] lo;
  logic [1:0] col;
  logic       bside;
  op_entry_t  e;

  assign lo = op[3:0];
  assign col = op[5:4];
  assign bside = op[6];

  always_comb begin
    e = '{MN_ILL, MD_INV};
    if (page == 2'd0) begin
      unique case (op[7:4])
        4'h0: e = '{MEM_OPS[lo], MD_DIR};
        4'h1: e = ROW1[lo];
        4'h2: e = '{SHORT_BR[lo], MD_REB};
        4'h3: e = ROW3[lo];
        4'h4: e = '{ACCA_OPS[lo], MD_IMP};
        4'h5: e = '{ACCB_OPS[lo], MD_IMP};
        4'h6: e = '{MEM_OPS[lo], MD_IND};
        4'h7: e = '{MEM_OPS[lo], MD_EXT};
        default: begin
          e.mn = bside ? SIDE_B[lo] : SIDE_A[lo];
          e.md = COL_MODE[col];
          if (col == 2'd0) begin
            if (lo == 4'd7 || lo == 4'd15 || (bside && lo == 4'd13)) begin
              e.mn = MN_ILL;
            end else if (lo == 4'd13) begin
              e = '{MN_BSR, MD_REB};
            end else if (lo != 4'd3 && lo != 4'd12 && lo != 4'd14) begin
              e.md = MD_IMB;
            end
          end
        end
      endcase
    end else if (page == 2'd1) begin
      if (op >= 8'h21 && op <= 8'h2F) begin
        e = '{SHORT_BR[lo] + 8'd1, MD_REW};
      end else if (op == 8'h3F) begin
        e = '{MN_SWI2, MD_IMP};
      end else if (op[7]) begin
        if (!bside) begin
          if (lo == 4'd3) e.mn = MN_CMPD;
          else if (lo == 4'd12) e.mn = MN_CMPY;
          else if (lo == 4'd14) e.mn = MN_LDY;
          else if (lo == 4'd15 && col != 2'd0) e.mn = MN_STY;
        end else begin
          if (lo == 4'd14) e.mn = MN_LDS;
          else if (lo == 4'd15 && col != 2'd0) e.mn = MN_STS;
        end
        e.md = COL_MODE[col];
      end
    end else begin
      if (op == 8'h3F) begin
        e = '{MN_SWI3, MD_IMP};
      end else if (op[7] && !bside) begin
        if (lo == 4'd3) e.mn = MN_CMPU;
        else if (lo == 4'd12) e.mn = MN_CMPS;
        e.md = COL_MODE[col];
      end
    end
    entry = e;
    if (e.mn == MN_ILL) entry.md = MD_INV;
  end

endmodule

// File: rtl/core/ilpd_index.sv
// Indexed postbyte decode: form, indirect flag, offset, extra bytes.
module ilpd_index import ilpd_pkg::*; (
  input  logic        [7:0]  post,
  input  logic        [7:0]  b1,
  input  logic        [7:0]  b2,
  output iform_t             form,
  output logic               indirect,
  output logic signed [16:0] offset,
  output logic        [1:0]  extra,
  output logic               valid
);

  logic [15:0] w16;
  assign w16 = {b1, b2};

  always_comb begin
    form = IF_5BIT;
    indirect = 1'b0;
    offset = '0;
    extra = 2'd0;
    valid = 1'b1;
    if (!post[7]) begin
      offset = {{12{post[4]}}, post[4:0]};
    end else begin
      indirect = post[4];
      unique case (post[3:0])
        4'h0: begin form = IF_INC1; valid = !post[4]; end
        4'h1: form = IF_INC2;
        4'h2: begin form = IF_DEC1; valid = !post[4]; end
        4'h3: form = IF_DEC2;
        4'h4: form = IF_ZERO;
        4'h5: form = IF_ACCB;
        4'h6: form = IF_ACCA;
        4'h8: begin form = IF_OFF8; extra = 2'd1; offset = {9'd0, b1}; end
        4'h9: begin form = IF_OFF16; extra = 2'd2; offset = {1'b0, w16}; end
        4'hB: form = IF_ACCD;
        4'hC: begin form = IF_PC8; extra = 2'd1; offset = {9'd0, b1}; end
        4'hD: begin form = IF_PC16; extra = 2'd2; offset = {1'b0, w16}; end
        4'hF: begin
          if (post == EXT_IND_POST) begin
            form = IF_EXTIND; extra = 2'd2; offset = {1'b0, w16};
          end else begin
            valid = 1'b0;
          end
        end
        default: valid = 1'b0;
      endcase
      if (!valid) begin
        form = IF_ILL; indirect = 1'b0; offset = '0; extra = 2'd0;
      end
    end
  end

endmodule

// File: bench/instruction_length_predecoder_checker.sv
// Checker for the instruction length predecoder: predicts each decode and compares it.
`timescale 1ns / 1ps
module instruction_length_predecoder_checker import ilpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic        [15:0] instr_address,
  input  logic        [7:0]  byte_zero,
  input  logic        [7:0]  byte_one,
  input  logic        [7:0]  byte_two,
  input  logic        [7:0]  byte_three,
  input  logic        [7:0]  byte_four,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic        [2:0]  length,
  input  logic        [1:0]  page,
  input  logic        [7:0]  mnemonic,
  input  logic        [3:0]  mode,
  input  logic        [15:0] operand,
  input  logic        [7:0]  postbyte,
  input  logic        [1:0]  index_register,
  input  logic        [3:0]  index_form,
  input  logic               index_indirect,
  input  logic signed [16:0] index_offset,
  input  logic               index_valid,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [2:0]  len;
    logic [1:0]  pg;
    logic [7:0]  mn;
    logic [3:0]  md;
    logic [15:0] opnd;
    logic [7:0]  post;
    logic [1:0]  ireg;
    logic [3:0]  iform;
    logic        iind;
    logic [16:0] ioff;
    logic        ivalid;
  } decode_t;

  decode_t expected_decodes[$];

  function automatic op_entry_t opcode_lookup(input logic [1:0] pg, input logic [7:0] op);
    op_entry_t e;
    logic [3:0] lo;
    logic [1:0] col;
    logic bside;
    e = '{MN_ILL, MD_INV};
    lo = op[3:0];
    col = op[5:4];
    bside = op[6];
    if (pg == 2'd0) begin
      if (op < 8'h10) e = '{MEM_OPS[lo], MD_DIR};
      else if (op < 8'h20) e = ROW1[lo];
      else if (op < 8'h30) e = '{SHORT_BR[lo], MD_REB};
      else if (op < 8'h40) e = ROW3[lo];
      else if (op < 8'h50) e = '{ACCA_OPS[lo], MD_IMP};
      else if (op < 8'h60) e = '{ACCB_OPS[lo], MD_IMP};
      else if (op < 8'h70) e = '{MEM_OPS[lo], MD_IND};
      else if (op < 8'h80) e = '{MEM_OPS[lo], MD_EXT};
      else begin
        e.mn = bside ? SIDE_B[lo] : SIDE_A[lo];
        e.md = COL_MODE[col];
        if (col == 2'd0) begin
          if (lo == 4'd7 || lo == 4'd15 || (bside && lo == 4'd13)) e.mn = MN_ILL;
          else if (lo == 4'd13) e = '{MN_BSR, MD_REB};
          else if (lo != 4'd3 && lo != 4'd12 && lo != 4'd14) e.md = MD_IMB;
        end
      end
    end else if (pg == 2'd1) begin
      if (op >= 8'h21 && op <= 8'h2F) e = '{SHORT_BR[lo] + 8'd1, MD_REW};
      else if (op == 8'h3F) e = '{MN_SWI2, MD_IMP};
      else if (op >= 8'h80) begin
        if (!bside) begin
          if (lo == 4'd3) e.mn = MN_CMPD;
          else if (lo == 4'd12) e.mn = MN_CMPY;
          else if (lo == 4'd14) e.mn = MN_LDY;
          else if (lo == 4'd15 && col != 2'd0) e.mn = MN_STY;
        end else begin
          if (lo == 4'd14) e.mn = MN_LDS;
          else if (lo == 4'd15 && col != 2'd0) e.mn = MN_STS;
        end
        e.md = COL_MODE[col];
      end
    end else begin
      if (op == 8'h3F) e = '{MN_SWI3, MD_IMP};
      else if (op >= 8'h80 && !bside) begin
        if (lo == 4'd3) e.mn = MN_CMPU;
        else if (lo == 4'd12) e.mn = MN_CMPS;
        e.md = COL_MODE[col];
      end
    end
    if (e.mn == MN_ILL) e.md = MD_INV;
    return e;
  endfunction

  function automatic decode_t predict_decode(input logic [15:0] addr, input logic [7:0] b [5]);
    decode_t d;
    op_entry_t e;
    int n;
    int extra;
    logic [7:0] t;
    logic [15:0] w16;
    d = '0;
    if (b[0] == PREFIX_P1) d.pg = 2'd1;
    else if (b[0] == PREFIX_P2) d.pg = 2'd2;
    n = (d.pg != 2'd0) ? 1 : 0;
    e = opcode_lookup(d.pg, b[n]);
    n++;
    d.mn = e.mn;
    d.md = e.md;
    d.len = 3'(n);
    case (e.md)
      MD_IMB, MD_DIR: begin
        d.opnd = {8'd0, b[n]};
        d.len = 3'(n + 1);
      end
      MD_IMW, MD_EXT: begin
        d.opnd = {b[n], b[n + 1]};
        d.len = 3'(n + 2);
      end
      MD_REB: begin
        d.len = 3'(n + 1);
        d.opnd = addr + 16'(n + 1) + {{8{b[n][7]}}, b[n]};
      end
      MD_REW: begin
        d.len = 3'(n + 2);
        d.opnd = addr + 16'(n + 2) + {b[n], b[n + 1]};
      end
      MD_RPAIR, MD_SSTK, MD_USTK: begin
        d.post = b[n];
        d.len = 3'(n + 1);
      end
      MD_IND: begin
        t = b[n];
        w16 = {b[n + 1], b[n + 2]};
        extra = 0;
        d.post = t;
        d.ireg = t[6:5];
        d.ivalid = 1'b1;
        if (!t[7]) begin
          d.iform = IF_5BIT;
          d.ioff = {{12{t[4]}}, t[4:0]};
        end else begin
          d.iind = t[4];
          case (t[3:0])
            4'h0: begin d.iform = IF_INC1; if (d.iind) d.ivalid = 1'b0; end
            4'h1: d.iform = IF_INC2;
            4'h2: begin d.iform = IF_DEC1; if (d.iind) d.ivalid = 1'b0; end
            4'h3: d.iform = IF_DEC2;
            4'h4: d.iform = IF_ZERO;
            4'h5: d.iform = IF_ACCB;
            4'h6: d.iform = IF_ACCA;
            4'h8: begin d.iform = IF_OFF8; extra = 1; d.ioff = {9'd0, b[n + 1]}; end
            4'h9: begin d.iform = IF_OFF16; extra = 2; d.ioff = {1'b0, w16}; end
            4'hB: d.iform = IF_ACCD;
            4'hC: begin d.iform = IF_PC8; extra = 1; d.ioff = {9'd0, b[n + 1]}; end
            4'hD: begin d.iform = IF_PC16; extra = 2; d.ioff = {1'b0, w16}; end
            4'hF: begin
              if (t == EXT_IND_POST) begin
                d.iform = IF_EXTIND; extra = 2; d.ioff = {1'b0, w16};
              end else d.ivalid = 1'b0;
            end
            default: d.ivalid = 1'b0;
          endcase
          if (!d.ivalid) begin
            d.iform = IF_ILL; d.iind = 1'b0; d.ioff = '0; extra = 0;
          end
        end
        d.len = 3'(n + 1 + extra);
      end
      default: ;
    endcase
    return d;
  endfunction

  assign pending_count = expected_decodes.size();

  always @(posedge clk) begin
    logic [7:0] win [5];
    decode_t got;
    decode_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        win = '{byte_zero, byte_one, byte_two, byte_three, byte_four};
        expected_decodes.push_back(predict_decode(instr_address, win));
      end
      if (out_valid && !out_stall) begin
        got = '{length, page, mnemonic, mode, operand, postbyte, index_register,
                index_form, index_indirect, index_offset, index_valid};
        if (expected_decodes.size() == 0) begin
          $display("%t: unexpected item %h", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_decodes.pop_front();
          if (got !== want) begin
            $display("%t: mismatch expected len=%0d pg=%0d mn=%0d md=%0d op=%h post=%h",
                     $realtime, want.len, want.pg, want.mn, want.md, want.opnd, want.post);
            $display("  reg=%0d form=%0d ind=%0d off=%h valid=%0d",
                     want.ireg, want.iform, want.iind, want.ioff, want.ivalid);
            $display("  actual len=%0d pg=%0d mn=%0d md=%0d op=%h post=%h",
                     got.len, got.pg, got.mn, got.md, got.opnd, got.post);
            $display("  reg=%0d form=%0d ind=%0d off=%h valid=%0d",
                     got.ireg, got.iform, got.iind, got.ioff, got.ivalid);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: bench/instruction_length_predecoder_top_tb.sv
// Testbench top for the instruction length predecoder: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module instruction_length_predecoder_top_tb;
  import ilpd_pkg::*;

  localparam int RANDOM_ITEMS = 930;
  localparam int QUIET_PART   = 150;
  localparam int WATCHDOG_MAX = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] instr_address = '0;
  logic [7:0] byte_zero = '0, byte_one = '0, byte_two = '0, byte_three = '0, byte_four = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] length;
  logic [1:0] page;
  logic [7:0] mnemonic;
  logic [3:0] mode;
  logic [15:0] operand;
  logic [7:0] postbyte;
  logic [1:0] index_register;
  logic [3:0] index_form;
  logic index_indirect;
  logic signed [16:0] index_offset;
  logic index_valid;
  int fail_count;
  int pending_count;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  instruction_length_predecoder_top i_dut (.*);
  instruction_length_predecoder_checker i_checker (.*);

  // watchdog: count cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls in bursts until the quiet part
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(negedge clk);
    end
  end

  task automatic send_item(input logic [15:0] addr, input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3, input logic [7:0] b4);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    instr_address <= addr;
    {byte_zero, byte_one, byte_two, byte_three, byte_four} <= {b0, b1, b2, b3, b4};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] b0, b1, b2;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    // directed: extremes, prefixes, branches, indexed forms
    send_item(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(16'hFFFE, 8'h20, 8'h7F, 8'h00, 8'h00, 8'h00);
    send_item(16'h0001, 8'h20, 8'h80, 8'h00, 8'h00, 8'h00);
    send_item(16'hFFF0, 8'h17, 8'hFF, 8'hFF, 8'h00, 8'h00);
    send_item(16'h8000, 8'h10, 8'h2E, 8'h80, 8'h00, 8'h00);
    send_item(16'h1234, 8'h10, 8'h10, 8'h00, 8'h00, 8'h00);
    send_item(16'h1234, 8'h11, 8'h11, 8'h00, 8'h00, 8'h00);
    send_item(16'h1234, 8'h11, 8'h3F, 8'h00, 8'h00, 8'h00);
    send_item(16'h1234, 8'h10, 8'h3F, 8'h00, 8'h00, 8'h00);
    send_item(16'h1234, 8'h10, 8'hFF, 8'hAB, 8'hCD, 8'h00);
    send_item(16'h1234, 8'h11, 8'hB3, 8'h12, 8'h34, 8'h00);
    send_item(16'h4321, 8'h8D, 8'hF0, 8'h00, 8'h00, 8'h00);
    send_item(16'h4321, 8'hCD, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(16'h4321, 8'h1F, 8'h89, 8'h00, 8'h00, 8'h00);
    send_item(16'h4321, 8'h34, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_item(16'h4321, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(16'h0000, 8'h30, 8'h10, 8'h00, 8'h00, 8'h00);
    send_item(16'h0000, 8'h30, 8'h0F, 8'h00, 8'h00, 8'h00);
    send_item(16'h0000, 8'h30, 8'h9F, 8'hBE, 8'hEF, 8'h00);
    send_item(16'h0000, 8'h30, 8'hBF, 8'hBE, 8'hEF, 8'h00);
    send_item(16'h0000, 8'h10, 8'hAE, 8'h90, 8'h00, 8'h00);
    send_item(16'h0000, 8'h6E, 8'hE9, 8'h80, 8'h01, 8'h00);
    send_item(16'h0000, 8'hA6, 8'hFC, 8'hFF, 8'h00, 8'h00);
    // random: mostly indexed and prefixed opcodes, with postbytes spread widely
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_PART) quiet = 1'b1;
      b0 = 8'($urandom);
      b1 = 8'($urandom);
      b2 = 8'($urandom);
      case ($urandom_range(0, 3))
        0: begin b0 = $urandom_range(0, 1) ? 8'h10 : 8'h11; end
        1: begin b0 = {2'b10 | b0[7:6], 2'b10, b0[3:0]}; b0[7] = 1'b1; end
        2: begin b0 = {2'b01, 2'b10, b0[3:0]}; end
        default: ;
      endcase
      if (b0 == 8'h10 || b0 == 8'h11) begin
        if ($urandom_range(0, 1)) b1 = {1'b1, b1[6], 2'b10, b1[3:0]};
      end
      send_item(16'($urandom), b0, b1, b2, 8'($urandom), 8'($urandom));
    end
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
